/* hw/rtl/ord_pkg.sv */
// Shared types, codes and constants of the overwriting ring deque.
package ord_pkg;

  localparam int MAX_SLOTS_DEF = 16;
  localparam int DATA_BITS_DEF = 32;

  localparam int OP_BITS    = 3;
  localparam int VALUE_BITS = 32;
  localparam int INDEX_BITS = 4;
  localparam int COUNT_BITS = 4;
  localparam int CFG_BITS   = 5;
  localparam int APB_BITS   = 32;
  localparam int PADDR_BITS = 3;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

  localparam logic REG_SLOTS_IN_USE = 1'b0;

  typedef enum logic [OP_BITS-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_SLOT  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic rd_slot;
    logic latch_slot;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

/* hw/rtl/ord_ram.sv */
// Generic RAM: one write port, two registered read ports.
module ord_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hw/rtl/ord_ctrl.sv */
// Sequencing state machine of the overwriting ring deque.
module ord_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ord_pkg::dp_status_t status,
  output ord_pkg::ctrl_cmd_t  cmd
);

  import ord_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        cmd.rd_slot = 1'b1;
        state_next  = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.latch_slot = 1'b1;
        state_next     = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/ord_dp.sv */
// Datapath: ring pointers, size register, slot RAM and result register.
module ord_dp #(
  parameter int MAX_SLOTS = ord_pkg::MAX_SLOTS_DEF,
  parameter int DATA_BITS = ord_pkg::DATA_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ord_pkg::ctrl_cmd_t              cmd,
  output ord_pkg::dp_status_t             status,
  input  logic                            cfg_we,
  input  logic [ord_pkg::CFG_BITS-1:0]    cfg_wdata,
  output logic [ord_pkg::CFG_BITS-1:0]    cfg_slots,
  input  logic [ord_pkg::OP_BITS-1:0]     op,
  input  logic [ord_pkg::VALUE_BITS-1:0]  value,
  input  logic [ord_pkg::INDEX_BITS-1:0]  slot_index,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [ord_pkg::VALUE_BITS-1:0]  read_data,
  output logic [ord_pkg::VALUE_BITS-1:0]  front_value,
  output logic [ord_pkg::VALUE_BITS-1:0]  back_value,
  output logic [ord_pkg::COUNT_BITS-1:0]  item_count,
  output logic                            is_empty,
  output logic                            dropped,
  output logic                            underflow
);

  import ord_pkg::*;

  localparam int PW = $clog2(MAX_SLOTS);
  localparam int NW = $clog2(MAX_SLOTS + 1);
  localparam int WW = (NW > CFG_BITS) ? NW : CFG_BITS;
  localparam int CW = (NW > INDEX_BITS) ? ((NW > COUNT_BITS) ? NW : COUNT_BITS)
                                        : ((INDEX_BITS > COUNT_BITS) ? INDEX_BITS
                                                                     : COUNT_BITS);
  localparam int XW = DATA_BITS + VALUE_BITS;

  logic [CFG_BITS-1:0]   slots;
  logic [PW-1:0]         head;
  logic [PW-1:0]         tail;
  logic [PW-1:0]         head_next;
  logic [PW-1:0]         tail_next;
  logic [OP_BITS-1:0]    op_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic                  drop_q;
  logic                  under_q;
  logic                  drop_next;
  logic                  under_next;
  logic [DATA_BITS-1:0]  slot_q;

  logic [NW-1:0]         n;
  logic [WW-1:0]         slots_ext;
  logic [NW-1:0]         head_w;
  logic [NW-1:0]         tail_w;
  logic [PW-1:0]         head_up;
  logic [PW-1:0]         tail_up;
  logic [PW-1:0]         head_dn;
  logic [PW-1:0]         tail_dn;
  logic [NW-1:0]         cnt;
  logic [CW-1:0]         cnt_ext;
  logic [CW-1:0]         idx_ext;
  logic [CW-1:0]         n_ext;
  logic [PW-1:0]         slot_addr;

  logic                  wr_en;
  logic [PW-1:0]         wr_addr;
  logic [XW-1:0]         wr_ext;
  logic [DATA_BITS-1:0]  rdata_a;
  logic [DATA_BITS-1:0]  rdata_b;
  logic [PW-1:0]         raddr_a;
  logic [XW-1:0]         front_ext;
  logic [XW-1:0]         back_ext;
  logic [XW-1:0]         slot_ext;

  function automatic logic [PW-1:0] step_up(logic [PW-1:0] p, logic [NW-1:0] size);
    logic [NW-1:0] q;
    q = NW'(p) + NW'(1);
    return (q >= size) ? '0 : q[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] step_down(logic [PW-1:0] p, logic [NW-1:0] size);
    logic [NW-1:0] q;
    q = (p == '0) ? (size - NW'(1)) : (NW'(p) - NW'(1));
    return q[PW-1:0];
  endfunction

  assign slots_ext = WW'(slots);
  always_comb begin
    if (slots == '0) begin
      n = NW'(1);
    end else if (slots_ext > WW'(MAX_SLOTS)) begin
      n = NW'(MAX_SLOTS);
    end else begin
      n = slots_ext[NW-1:0];
    end
  end

  assign head_w  = NW'(head);
  assign tail_w  = NW'(tail);
  assign head_up = step_up(head, n);
  assign tail_up = step_up(tail, n);
  assign head_dn = step_down(head, n);
  assign tail_dn = step_down(tail, n);
  assign cnt     = (tail_w >= head_w) ? (tail_w - head_w) : (n - (head_w - tail_w));
  assign cnt_ext = CW'(cnt);

  assign idx_ext   = CW'(idx_q);
  assign n_ext     = CW'(n);
  assign slot_addr = (idx_ext != '0 && idx_ext < n_ext) ? idx_ext[PW-1:0] : '0;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    drop_next  = 1'b0;
    under_next = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = tail;
    unique case (op_t'(op_q))
      OP_PUSH_BACK: begin
        wr_en     = 1'b1;
        tail_next = tail_up;
        if (tail_up == head) begin
          head_next = head_up;
          drop_next = 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        wr_en     = 1'b1;
        wr_addr   = head_dn;
        head_next = head_dn;
        if (cnt == n - NW'(1)) begin
          tail_next = tail_dn;
          drop_next = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (head == tail) begin
          under_next = 1'b1;
        end else begin
          head_next = head_up;
        end
      end
      OP_POP_BACK: begin
        if (head == tail) begin
          under_next = 1'b1;
        end else begin
          tail_next = tail_dn;
        end
      end
      default: begin
      end
    endcase
  end

  assign wr_ext  = {{DATA_BITS{1'b0}}, value_q};
  assign raddr_a = cmd.rd_slot ? slot_addr : head;

  ord_ram #(
    .WIDTH(DATA_BITS),
    .DEPTH(MAX_SLOTS)
  ) u_ram (
    .clk    (clk),
    .we     (cmd.execute && wr_en),
    .waddr  (wr_addr),
    .wdata  (wr_ext[DATA_BITS-1:0]),
    .raddr_a(raddr_a),
    .rdata_a(rdata_a),
    .raddr_b(tail_dn),
    .rdata_b(rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slots <= CFG_RESET;
      head  <= '0;
      tail  <= '0;
    end else if (cfg_we) begin
      slots <= cfg_wdata;
      head  <= '0;
      tail  <= '0;
    end else if (cmd.execute) begin
      head <= head_next;
      tail <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op;
      value_q <= value;
      idx_q   <= slot_index;
    end
    if (cmd.execute) begin
      drop_q  <= drop_next;
      under_q <= under_next;
    end
    if (cmd.latch_slot) begin
      slot_q <= rdata_a;
    end
  end

  assign front_ext = {{VALUE_BITS{1'b0}}, rdata_a};
  assign back_ext  = {{VALUE_BITS{1'b0}}, rdata_b};
  assign slot_ext  = {{VALUE_BITS{1'b0}}, slot_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_data   <= (op_t'(op_q) == OP_READ_SLOT) ? slot_ext[VALUE_BITS-1:0] : '0;
      front_value <= (cnt == '0) ? '0 : front_ext[VALUE_BITS-1:0];
      back_value  <= (cnt == '0) ? '0 : back_ext[VALUE_BITS-1:0];
      item_count  <= cnt_ext[COUNT_BITS-1:0];
      is_empty    <= (head == tail);
      dropped     <= drop_q;
      underflow   <= under_q;
    end
  end

  assign status.out_busy = out_valid && out_stall;
  assign cfg_slots       = slots;

endmodule

/* hw/rtl/overwriting_ring_deque.sv */
// Top level of the overwriting ring deque: APB register, controller, datapath.
//
// A double-ended queue in a ring of slots_in_use slots (at most MAX_SLOTS),
// holding up to slots_in_use - 1 items; a push into a full ring drops the
// item at the opposite end.
// Input channel (in_valid / in_stall): op, value, slot_index. An item is
// taken when in_valid is high and in_stall low.
// Output channel (out_valid / out_stall): one result per item, held in an
// output register until taken.
// One item is in work at a time; its steps, in order: take the item;
// update the pointers, write the slot and read the slot; read the head and
// back on the two read ports; load the result. The next item is taken
// while a result waits in the output register; it waits in its last step
// until that result is taken.
// Reset (rst, synchronous) empties the queue and sets slots_in_use to 16;
// slot contents are not cleared. Writing slots_in_use over APB (address 0)
// empties the queue as well.
module overwriting_ring_deque #(
  parameter int MAX_SLOTS = ord_pkg::MAX_SLOTS_DEF,
  parameter int DATA_BITS = ord_pkg::DATA_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ord_pkg::OP_BITS-1:0]      op,
  input  logic [ord_pkg::VALUE_BITS-1:0]   value,
  input  logic [ord_pkg::INDEX_BITS-1:0]   slot_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ord_pkg::VALUE_BITS-1:0]   read_data,
  output logic [ord_pkg::VALUE_BITS-1:0]   front_value,
  output logic [ord_pkg::VALUE_BITS-1:0]   back_value,
  output logic [ord_pkg::COUNT_BITS-1:0]   item_count,
  output logic                             is_empty,
  output logic                             dropped,
  output logic                             underflow,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ord_pkg::PADDR_BITS-1:0]   paddr,
  input  logic [ord_pkg::APB_BITS-1:0]     pwdata,
  output logic [ord_pkg::APB_BITS-1:0]     prdata,
  output logic                             pready
);

  import ord_pkg::*;

  ctrl_cmd_t           cmd;
  dp_status_t          status;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_slots;
  logic                reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_SLOTS_IN_USE);
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? {{(APB_BITS-CFG_BITS){1'b0}}, cfg_slots} : '0;

  ord_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  ord_dp #(
    .MAX_SLOTS(MAX_SLOTS),
    .DATA_BITS(DATA_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_wdata  (pwdata[CFG_BITS-1:0]),
    .cfg_slots  (cfg_slots),
    .op         (op),
    .value      (value),
    .slot_index (slot_index),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .read_data  (read_data),
    .front_value(front_value),
    .back_value (back_value),
    .item_count (item_count),
    .is_empty   (is_empty),
    .dropped    (dropped),
    .underflow  (underflow)
  );

endmodule
